// ----- rtl/core/ers_pkg.sv -----
`timescale 1ns / 1ps

package ers_pkg;

	localparam int DATA_W = 32;

	// request codes
	localparam logic [1:0] REQ_COUNT  = 2'd0;
	localparam logic [1:0] REQ_CHECK  = 2'd1;
	localparam logic [1:0] REQ_REPORT = 2'd2;

	localparam logic [DATA_W-1:0] NO_MIN       = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] NO_MAX       = 32'hffff_ffff;
	localparam logic [DATA_W-1:0] WINDOW_RESET = 32'd1000;

	// commands from the sequencer to the interval statistics
	typedef struct packed {
		logic delta;
		logic apply;
		logic clear;
	} ers_cmd_t;

	// interval statistics as seen by the sequencer
	typedef struct packed {
		logic [DATA_W-1:0] interval;
		logic [DATA_W-1:0] min_val;
		logic [DATA_W-1:0] max_val;
		logic [DATA_W-1:0] total;
	} ers_stats_t;

endpackage

// ----- rtl/core/event_rate_and_interval_stats_core.sv -----
`timescale 1ns / 1ps

// event rate and interval statistics meter on a millisecond time base. each input beat
// carries a request (count event and check window, check window only, or report and
// clear min/max/total) and the current time; exactly one output beat follows each input
// beat. a counting request steps through delta, apply, elapsed and check; a check only
// request goes straight to elapsed and check. a request that closes the window then
// forms count * 1000 and starts the two bit-serial 32-bit dividers (rate and average
// interval), which run side by side. a report request snapshots the statistics and
// clears min/max/total. the input stalls while a request is in work; a finished beat
// waits in the output register, so the next input beat is taken while it is still pending.
// the user must write window_ms through cfg_we / cfg_wdata only while the block is idle;
// the block itself does not enforce this. a value of zero acts as a 1 ms window.
module event_rate_and_interval_stats_core (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [31:0]         now_ms,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                window_done,
	output logic [31:0]         rate_per_second,
	output logic [31:0]         last_interval,
	output logic signed [31:0]  min_interval,
	output logic signed [31:0]  max_interval,
	output logic [31:0]         total_interval,
	output logic [31:0]         avg_interval
);

	localparam int W = ers_pkg::DATA_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_APPLY,
		ST_ELAPSED,
		ST_CHECK,
		ST_MUL1,
		ST_MUL2,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_FINISH,
		ST_REPORT
	} state_t;

	state_t state_q;

	// accepted beat
	logic [W-1:0] now_q;

	// window and result state
	logic [W-1:0] window_ms_q;
	logic [W-1:0] window_start_q;
	logic [W-1:0] count_q;
	logic [W-1:0] rate_q;
	logic [W-1:0] avg_q;
	logic [W-1:0] elapsed_q;
	logic [W-1:0] prod_q;
	logic         closed_q;

	// output register
	logic         out_valid_q;
	logic         out_done_q;
	logic [W-1:0] out_rate_q;
	logic [W-1:0] out_interval_q;
	logic [W-1:0] out_min_q;
	logic [W-1:0] out_max_q;
	logic [W-1:0] out_total_q;
	logic [W-1:0] out_avg_q;

	ers_pkg::ers_cmd_t   cmd;
	ers_pkg::ers_stats_t stats;

	logic         in_fire;
	logic         slot_free;
	logic         out_load;
	logic [W-1:0] limit;
	logic         div_start;
	logic         rate_done;
	logic         avg_done;
	logic [W-1:0] rate_quo;
	logic [W-1:0] avg_quo;

	assign in_fire   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	// output register can take a new beat this cycle
	assign slot_free = !out_valid_q || !out_stall;
	// a finished beat enters the output register this cycle
	assign out_load  = slot_free && ((state_q == ST_FINISH) || (state_q == ST_REPORT));
	// zero length window behaves as 1 ms
	assign limit     = (window_ms_q == '0) ? W'(1) : window_ms_q;
	assign div_start = (state_q == ST_DIVGO);

	always_comb begin
		cmd       = '0;
		cmd.delta = (state_q == ST_DELTA);
		cmd.apply = (state_q == ST_APPLY);
		cmd.clear = (state_q == ST_REPORT) && slot_free;
	end

	ers_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.now_ms (now_q),
		.stats  (stats)
	);

	// events * 1000 / elapsed
	ers_div u_rate_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (elapsed_q),
		.done     (rate_done),
		.quotient (rate_quo)
	);

	// total / events, kept only when the window held events
	ers_div u_avg_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (stats.total),
		.divisor  (count_q),
		.done     (avg_done),
		.quotient (avg_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q <= ers_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_ms_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q <= now_ms;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_start_q <= '0;
			count_q        <= '0;
			rate_q         <= '0;
			avg_q          <= '0;
			elapsed_q      <= '0;
			prod_q         <= '0;
			closed_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			out_done_q     <= 1'b0;
			out_rate_q     <= '0;
			out_interval_q <= '0;
			out_min_q      <= '0;
			out_max_q      <= '0;
			out_total_q    <= '0;
			out_avg_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					closed_q <= 1'b0;
					if (in_fire) begin
						case (req_type)
							ers_pkg::REQ_COUNT:  state_q <= ST_DELTA;
							ers_pkg::REQ_REPORT: state_q <= ST_REPORT;
							default:             state_q <= ST_ELAPSED;
						endcase
					end
				end
				ST_DELTA: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_ELAPSED;
				end
				ST_ELAPSED: begin
					elapsed_q <= now_q - window_start_q;
					state_q   <= ST_CHECK;
				end
				ST_CHECK: begin
					if (elapsed_q < limit) begin
						state_q <= ST_FINISH;
					end else begin
						// count * 1000 as (c << 10) - (c << 5) + (c << 3), wrapping
						prod_q   <= (count_q << 10) - (count_q << 5);
						closed_q <= 1'b1;
						state_q  <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					prod_q  <= prod_q + (count_q << 3);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (rate_done && avg_done) begin
						rate_q         <= rate_quo;
						if (count_q != '0) begin
							avg_q <= avg_quo;
						end
						window_start_q <= now_q;
						count_q        <= '0;
						state_q        <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						out_valid_q    <= 1'b1;
						out_done_q     <= closed_q;
						out_rate_q     <= rate_q;
						out_interval_q <= stats.interval;
						out_min_q      <= stats.min_val;
						out_max_q      <= stats.max_val;
						out_total_q    <= stats.total;
						out_avg_q      <= avg_q;
						state_q        <= ST_IDLE;
					end
				end
				ST_REPORT: begin
					// snapshot taken in the same cycle the clear is issued
					if (slot_free) begin
						out_valid_q    <= 1'b1;
						out_done_q     <= 1'b0;
						out_rate_q     <= rate_q;
						out_interval_q <= stats.interval;
						out_min_q      <= stats.min_val;
						out_max_q      <= stats.max_val;
						out_total_q    <= stats.total;
						out_avg_q      <= avg_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign window_done     = out_done_q;
	assign rate_per_second = out_rate_q;
	assign last_interval   = out_interval_q;
	assign min_interval    = $signed(out_min_q);
	assign max_interval    = $signed(out_max_q);
	assign total_interval  = out_total_q;
	assign avg_interval    = out_avg_q;

endmodule

// ----- rtl/core/ers_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module ers_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ers_pkg::DATA_W-1:0]   dividend,
	input  logic [ers_pkg::DATA_W-1:0]   divisor,
	output logic                         done,
	output logic [ers_pkg::DATA_W-1:0]   quotient
);

	localparam int W     = ers_pkg::DATA_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = !diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/ers_stats.sv -----
`timescale 1ns / 1ps

// interval since last counted event, min / max / total
module ers_stats (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ers_pkg::ers_cmd_t            cmd,
	input  logic [ers_pkg::DATA_W-1:0]   now_ms,
	output ers_pkg::ers_stats_t          stats
);

	localparam int W = ers_pkg::DATA_W;

	logic [W-1:0] last_q;
	logic [W-1:0] interval_q;
	logic [W-1:0] min_q;
	logic [W-1:0] max_q;
	logic [W-1:0] total_q;
	logic [W-1:0] delta_s1;

	always_ff @(posedge clk) begin
		if (cmd.delta) begin
			delta_s1 <= now_ms - last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			interval_q <= '0;
			min_q      <= ers_pkg::NO_MIN;
			max_q      <= ers_pkg::NO_MAX;
			total_q    <= '0;
		end else if (cmd.clear) begin
			min_q   <= ers_pkg::NO_MIN;
			max_q   <= ers_pkg::NO_MAX;
			total_q <= '0;
		end else if (cmd.apply) begin
			last_q     <= now_ms;
			interval_q <= delta_s1;
			total_q    <= total_q + delta_s1;
			if ($signed(max_q) < $signed(delta_s1)) begin
				max_q <= delta_s1;
			end
			if ($signed(min_q) > $signed(delta_s1)) begin
				min_q <= delta_s1;
			end
		end
	end

	assign stats.interval = interval_q;
	assign stats.min_val  = min_q;
	assign stats.max_val  = max_q;
	assign stats.total    = total_q;

endmodule
